FILE: src/sba_pkg.sv
// Shared constants, types and the arctangent table for the sweep angle unit.
`timescale 1ns / 1ps
package sba_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int ANGLE_SHIFT  = 30 - FRAC_BITS;
  localparam int CORDIC_STEPS = 30;
  localparam int NUM_SENSORS  = 4;
  localparam int TRIG_W       = 34;
  localparam int ANG_W        = 36;
  localparam int IN_W         = 72;
  localparam int OUT_W        = 80;

  localparam logic signed [ANG_W-1:0] ANG_PI      = 36'sd3373259426;
  localparam logic signed [ANG_W-1:0] HALF_PI     = 36'sd1686629713;
  localparam logic signed [ANG_W-1:0] TWO_PI      = 36'sd6746518852;
  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [2:0] REG_STATION = 3'd0;
  localparam logic [2:0] REG_ROT0    = 3'd1;
  localparam logic [2:0] REG_ROT1    = 3'd2;
  localparam logic [2:0] REG_ROT2    = 3'd3;
  localparam logic [2:0] REG_TILT    = 3'd4;
  localparam logic [2:0] REG_OFFS_X  = 3'd5;
  localparam logic [2:0] REG_OFFS_Y  = 3'd6;

  // One pose after the front end: position plus heading and tilt sine/cosine in Q.30.
  typedef struct packed {
    logic signed [23:0]       car_x;
    logic signed [23:0]       car_y;
    logic signed [TRIG_W-1:0] hc;
    logic signed [TRIG_W-1:0] hs;
    logic signed [TRIG_W-1:0] tc;
    logic signed [TRIG_W-1:0] ts;
  } sba_item_t;

  // atan(2^-i) in Q.30, rounded to nearest.
  function automatic logic signed [ANG_W-1:0] atan_entry(input logic [4:0] i);
    logic signed [ANG_W-1:0] v;
    case (i)
      5'd0:    v = 36'sd843314857;
      5'd1:    v = 36'sd497837829;
      5'd2:    v = 36'sd263043837;
      5'd3:    v = 36'sd133525159;
      5'd4:    v = 36'sd67021687;
      5'd5:    v = 36'sd33543516;
      5'd6:    v = 36'sd16775851;
      5'd7:    v = 36'sd8388437;
      5'd8:    v = 36'sd4194283;
      5'd9:    v = 36'sd2097149;
      5'd10:   v = 36'sd1048576;
      5'd30,
      5'd31:   v = '0;
      default: v = ANG_W'(36'sd1 <<< (30 - int'(i)));
    endcase
    return v;
  endfunction

endpackage

FILE: src/sba_front.sv
// Front end: accepts poses and computes heading and tilt sine/cosine by CORDIC.
`timescale 1ns / 1ps
module sba_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [23:0]       car_x,
  input  logic signed [23:0]       car_y,
  input  logic signed [18:0]       car_heading,
  input  logic signed [17:0]       plane_tilt,
  output logic                     out_valid,
  input  logic                     out_ready,
  output sba_pkg::sba_item_t       out_item
);

  localparam logic [1:0] FS_IDLE = 2'd0;
  localparam logic [1:0] FS_RUN  = 2'd1;
  localparam logic [1:0] FS_PUSH = 2'd2;

  localparam int AW = sba_pkg::ANG_W;
  localparam int TW = sba_pkg::TRIG_W;

  logic [1:0] state;
  logic [4:0] it;
  logic signed [23:0] px, py;
  logic signed [TW-1:0] hx, hy, tx, ty;
  logic signed [AW-1:0] hz, tz;
  logic hneg, tneg;
  logic signed [AW-1:0] atan_i;
  logic [AW:0] hfold, tfold;

  // Reduce to [-pi, pi], then fold into [-pi/2, pi/2]; the top bit marks a sign flip.
  function automatic logic [AW:0] fold(input logic signed [AW-1:0] a);
    logic signed [AW-1:0] r;
    logic neg;
    r = a;
    neg = 1'b0;
    if (r > sba_pkg::ANG_PI) r = r - sba_pkg::TWO_PI;
    if (r < -sba_pkg::ANG_PI) r = r + sba_pkg::TWO_PI;
    if (r > sba_pkg::HALF_PI) begin
      r = r - sba_pkg::ANG_PI;
      neg = 1'b1;
    end else if (r < -sba_pkg::HALF_PI) begin
      r = r + sba_pkg::ANG_PI;
      neg = 1'b1;
    end
    return {neg, r};
  endfunction

  always_comb begin
    hfold  = fold(AW'(car_heading) <<< sba_pkg::ANGLE_SHIFT);
    tfold  = fold(AW'(plane_tilt) <<< sba_pkg::ANGLE_SHIFT);
    atan_i = sba_pkg::atan_entry(it);
  end

  assign in_ready  = (state == FS_IDLE);
  assign out_valid = (state == FS_PUSH);

  always_comb begin
    out_item.car_x = px;
    out_item.car_y = py;
    out_item.hc    = hneg ? -hx : hx;
    out_item.hs    = hneg ? -hy : hy;
    out_item.tc    = tneg ? -tx : tx;
    out_item.ts    = tneg ? -ty : ty;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FS_IDLE;
      it    <= '0;
    end else begin
      unique case (state)
        FS_IDLE: begin
          if (in_valid) begin
            px    <= car_x;
            py    <= car_y;
            hneg  <= hfold[AW];
            hz    <= $signed(hfold[AW-1:0]);
            tneg  <= tfold[AW];
            tz    <= $signed(tfold[AW-1:0]);
            hx    <= sba_pkg::CORDIC_GAIN;
            hy    <= '0;
            tx    <= sba_pkg::CORDIC_GAIN;
            ty    <= '0;
            it    <= '0;
            state <= FS_RUN;
          end
        end
        FS_RUN: begin
          if (hz >= 0) begin
            hx <= hx - (hy >>> it);
            hy <= hy + (hx >>> it);
            hz <= hz - atan_i;
          end else begin
            hx <= hx + (hy >>> it);
            hy <= hy - (hx >>> it);
            hz <= hz + atan_i;
          end
          if (tz >= 0) begin
            tx <= tx - (ty >>> it);
            ty <= ty + (tx >>> it);
            tz <= tz - atan_i;
          end else begin
            tx <= tx + (ty >>> it);
            ty <= ty - (tx >>> it);
            tz <= tz + atan_i;
          end
          it <= it + 5'd1;
          if (it == 5'(sba_pkg::CORDIC_STEPS - 1)) state <= FS_PUSH;
        end
        FS_PUSH: begin
          if (out_ready) state <= FS_IDLE;
        end
        default: state <= FS_IDLE;
      endcase
    end
  end

endmodule

FILE: src/sba_queue.sv
// Two-entry queue between the front end and the back end.
`timescale 1ns / 1ps
module sba_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_valid,
  output logic               wr_ready,
  input  sba_pkg::sba_item_t wr_item,
  output logic               rd_valid,
  input  logic               rd_ready,
  output sba_pkg::sba_item_t rd_item
);

  sba_pkg::sba_item_t mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push, pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

endmodule

FILE: src/sba_back.sv
// Back end: per-sensor transform, atan, asin and result packing over shared units.
`timescale 1ns / 1ps
module sba_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  sba_pkg::sba_item_t             in_item,
  input  logic [62:0]                    station_position,
  input  logic [62:0]                    rotation_row_0,
  input  logic [62:0]                    rotation_row_1,
  input  logic [62:0]                    rotation_row_2,
  input  logic [63:0]                    sensor_x_offsets,
  input  logic [63:0]                    sensor_y_offsets,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sba_pkg::OUT_W-1:0]      out_data
);

  localparam logic [3:0] BS_IDLE = 4'd0;
  localparam logic [3:0] BS_MAC  = 4'd1;
  localparam logic [3:0] BS_CHK  = 4'd2;
  localparam logic [3:0] BS_VEC  = 4'd3;
  localparam logic [3:0] BS_MAG  = 4'd4;
  localparam logic [3:0] BS_NUM  = 4'd5;
  localparam logic [3:0] BS_DEN  = 4'd6;
  localparam logic [3:0] BS_ASIN = 4'd7;
  localparam logic [3:0] BS_DIV  = 4'd8;
  localparam logic [3:0] BS_SQ   = 4'd9;
  localparam logic [3:0] BS_SQRT = 4'd10;
  localparam logic [3:0] BS_AFIN = 4'd11;
  localparam logic [3:0] BS_SUM  = 4'd12;
  localparam logic [3:0] BS_OUT  = 4'd13;

  localparam logic [1:0] MAC_NONE = 2'd0;
  localparam logic [1:0] MAC_LOAD = 2'd1;
  localparam logic [1:0] MAC_ADD  = 2'd2;
  localparam logic [1:0] MAC_SUB  = 2'd3;

  localparam int AW = sba_pkg::ANG_W;
  localparam int TW = sba_pkg::TRIG_W;

  logic [3:0] state;
  logic [1:0] sensor;
  logic [3:0] mstep;
  logic [4:0] it;
  sba_pkg::sba_item_t item;

  logic signed [63:0] acc;
  logic signed [27:0] d0, d1;
  logic signed [31:0] b0, b1, b2;
  logic sflag;
  logic signed [AW-1:0] a1, asin_val;
  logic signed [TW-1:0] r;
  logic signed [AW-1:0] vx, vy, vz;
  logic vec_asin;
  logic signed [63:0] num, den;
  logic [63:0] rem, dabs_r;
  logic [29:0] q;
  logic neg;
  logic [61:0] sq_v, sq_res;
  logic [4:0] sq_k;
  logic [18:0] angles [sba_pkg::NUM_SENSORS];
  logic [sba_pkg::NUM_SENSORS-1:0] flags;

  // Combinational helpers.
  logic signed [15:0] ox, oy;
  logic signed [24:0] st0, st1, st2;
  logic signed [27:0] d2;
  logic signed [TW-1:0] mul_a;
  logic signed [27:0] mul_b;
  logic signed [TW+27:0] mul_p;
  logic [1:0] mac_op;
  logic signed [63:0] acc_r26, acc_r19;
  logic signed [AW-1:0] atan_i;
  logic signed [AW+TW-1:0] mag_p;
  logic signed [TW+31:0] num_p;
  logic signed [2*TW-1:0] den_p;
  logic signed [63:0] n_s, d_s;
  logic [63:0] n_abs, d_abs;
  logic n_neg;
  logic [63:0] rem2;
  logic [59:0] q_sq;
  logic [61:0] sq_bit, sq_try, sq_res_next, sq_v_next;
  logic signed [AW:0] ang_sum, ang_rnd;
  logic [18:0] ang_sat;

  function automatic logic signed [TW-1:0] rm_entry(input logic [62:0] row, input int k);
    return TW'($signed(row[21*k +: 21]));
  endfunction

  always_comb begin
    ox  = $signed(sensor_x_offsets[{sensor, 4'd0} +: 16]);
    oy  = $signed(sensor_y_offsets[{sensor, 4'd0} +: 16]);
    st0 = $signed({station_position[20:0], 4'd0});
    st1 = $signed({station_position[41:21], 4'd0});
    st2 = $signed({station_position[62:42], 4'd0});
    d2  = -(28'(st2));
    mul_a  = '0;
    mul_b  = '0;
    mac_op = MAC_NONE;
    unique case (mstep)
      4'd0:  begin mul_a = item.hc; mul_b = 28'(ox); mac_op = MAC_LOAD; end
      4'd1:  begin mul_a = item.hs; mul_b = 28'(oy); mac_op = MAC_SUB;  end
      4'd2:  begin mul_a = item.hs; mul_b = 28'(ox); mac_op = MAC_LOAD; end
      4'd3:  begin mul_a = item.hc; mul_b = 28'(oy); mac_op = MAC_ADD;  end
      4'd4:  begin mul_a = rm_entry(rotation_row_0, 0); mul_b = d0; mac_op = MAC_LOAD; end
      4'd5:  begin mul_a = rm_entry(rotation_row_1, 0); mul_b = d1; mac_op = MAC_ADD;  end
      4'd6:  begin mul_a = rm_entry(rotation_row_2, 0); mul_b = d2; mac_op = MAC_ADD;  end
      4'd7:  begin mul_a = rm_entry(rotation_row_0, 1); mul_b = d0; mac_op = MAC_LOAD; end
      4'd8:  begin mul_a = rm_entry(rotation_row_1, 1); mul_b = d1; mac_op = MAC_ADD;  end
      4'd9:  begin mul_a = rm_entry(rotation_row_2, 1); mul_b = d2; mac_op = MAC_ADD;  end
      4'd10: begin mul_a = rm_entry(rotation_row_0, 2); mul_b = d0; mac_op = MAC_LOAD; end
      4'd11: begin mul_a = rm_entry(rotation_row_1, 2); mul_b = d1; mac_op = MAC_ADD;  end
      4'd12: begin mul_a = rm_entry(rotation_row_2, 2); mul_b = d2; mac_op = MAC_ADD;  end
      default: ;
    endcase
    mul_p   = mul_a * mul_b;
    acc_r26 = (acc + 64'sd33554432) >>> 26;
    acc_r19 = (acc + 64'sd262144) >>> 19;
    atan_i  = sba_pkg::atan_entry(it);
    mag_p   = vx * sba_pkg::CORDIC_GAIN;
    num_p   = b2 * item.ts;
    den_p   = r * item.tc;
    // asin operand normalization: positive denominator, sign kept apart.
    n_s   = (den < 0) ? -num : num;
    d_s   = (den < 0) ? -den : den;
    n_neg = (n_s < 0);
    n_abs = n_neg ? 64'(-n_s) : 64'(n_s);
    d_abs = 64'(d_s);
    rem2  = {rem[62:0], 1'b0};
    q_sq  = q * q;
    sq_bit = 62'(1) << {sq_k, 1'b0};
    sq_try = sq_res + sq_bit;
    if (sq_v >= sq_try) begin
      sq_v_next   = sq_v - sq_try;
      sq_res_next = (sq_res >> 1) + sq_bit;
    end else begin
      sq_v_next   = sq_v;
      sq_res_next = sq_res >> 1;
    end
    ang_sum = (AW+1)'(a1) + (AW+1)'(asin_val);
    ang_rnd = (ang_sum + (AW+1)'(1 << (sba_pkg::ANGLE_SHIFT - 1))) >>> sba_pkg::ANGLE_SHIFT;
    if (ang_rnd > (AW+1)'(262143)) ang_sat = 19'h3ffff;
    else if (ang_rnd < -(AW+1)'(262144)) ang_sat = 19'h40000;
    else ang_sat = ang_rnd[18:0];
  end

  assign in_ready = (state == BS_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BS_IDLE;
      out_valid <= 1'b0;
      sensor    <= '0;
      mstep     <= '0;
      it        <= '0;
    end else begin
      if (out_valid && out_ready && state != BS_OUT) out_valid <= 1'b0;
      unique case (state)
        BS_IDLE: begin
          if (in_valid) begin
            item   <= in_item;
            sensor <= '0;
            mstep  <= '0;
            sflag  <= 1'b0;
            state  <= BS_MAC;
          end
        end
        BS_MAC: begin
          case (mac_op)
            MAC_LOAD: acc <= 64'(mul_p);
            MAC_ADD:  acc <= acc + 64'(mul_p);
            MAC_SUB:  acc <= acc - 64'(mul_p);
            default:  ;
          endcase
          case (mstep)
            4'd2:  d0 <= 28'(item.car_x) + 28'(acc_r26) - 28'(st0);
            4'd4:  d1 <= 28'(item.car_y) + 28'(acc_r26) - 28'(st1);
            4'd7:  b0 <= 32'(acc_r19);
            4'd10: b1 <= 32'(acc_r19);
            4'd13: b2 <= 32'(acc_r19);
            default: ;
          endcase
          mstep <= mstep + 4'd1;
          if (mstep == 4'd13) state <= BS_CHK;
        end
        BS_CHK: begin
          if (b0 == 0) begin
            sflag <= 1'b1;
            a1    <= (b1 > 0) ? sba_pkg::HALF_PI : ((b1 < 0) ? -sba_pkg::HALF_PI : '0);
            r     <= (b1 < 0) ? -TW'(b1) : TW'(b1);
            state <= BS_NUM;
          end else begin
            vx       <= (b0 < 0) ? -AW'(b0) : AW'(b0);
            vy       <= (b0 < 0) ? -AW'(b1) : AW'(b1);
            vz       <= '0;
            it       <= '0;
            vec_asin <= 1'b0;
            state    <= BS_VEC;
          end
        end
        BS_VEC: begin
          if (vy >= 0) begin
            vx <= vx + (vy >>> it);
            vy <= vy - (vx >>> it);
            vz <= vz + atan_i;
          end else begin
            vx <= vx - (vy >>> it);
            vy <= vy + (vx >>> it);
            vz <= vz - atan_i;
          end
          it <= it + 5'd1;
          if (it == 5'(sba_pkg::CORDIC_STEPS - 1)) state <= vec_asin ? BS_AFIN : BS_MAG;
        end
        BS_MAG: begin
          a1    <= vz;
          r     <= TW'((mag_p + (AW+TW)'(1 << 29)) >>> 30);
          state <= BS_NUM;
        end
        BS_NUM: begin
          num   <= 64'(num_p);
          state <= BS_DEN;
        end
        BS_DEN: begin
          den   <= 64'(den_p);
          state <= BS_ASIN;
        end
        BS_ASIN: begin
          neg <= n_neg;
          if (d_abs == 0) begin
            sflag    <= 1'b1;
            asin_val <= (n_abs == 0) ? '0 : (n_neg ? -sba_pkg::HALF_PI : sba_pkg::HALF_PI);
            state    <= BS_SUM;
          end else if (n_abs >= d_abs) begin
            if (n_abs > d_abs) sflag <= 1'b1;
            asin_val <= n_neg ? -sba_pkg::HALF_PI : sba_pkg::HALF_PI;
            state    <= BS_SUM;
          end else begin
            rem    <= n_abs;
            dabs_r <= d_abs;
            q      <= '0;
            it     <= '0;
            state  <= BS_DIV;
          end
        end
        BS_DIV: begin
          if (rem2 >= dabs_r) begin
            rem <= rem2 - dabs_r;
            q   <= {q[28:0], 1'b1};
          end else begin
            rem <= rem2;
            q   <= {q[28:0], 1'b0};
          end
          it <= it + 5'd1;
          if (it == 5'd29) state <= BS_SQ;
        end
        BS_SQ: begin
          sq_v   <= (62'(1) << 60) - 62'(q_sq);
          sq_res <= '0;
          sq_k   <= 5'd30;
          state  <= BS_SQRT;
        end
        BS_SQRT: begin
          sq_v   <= sq_v_next;
          sq_res <= sq_res_next;
          sq_k   <= sq_k - 5'd1;
          if (sq_k == 5'd0) begin
            vx       <= AW'(sq_res_next);
            vy       <= AW'(q);
            vz       <= '0;
            it       <= '0;
            vec_asin <= 1'b1;
            state    <= BS_VEC;
          end
        end
        BS_AFIN: begin
          asin_val <= neg ? -vz : vz;
          state    <= BS_SUM;
        end
        BS_SUM: begin
          angles[sensor] <= ang_sat;
          flags[sensor]  <= sflag;
          if (sensor == 2'(sba_pkg::NUM_SENSORS - 1)) begin
            state <= BS_OUT;
          end else begin
            sensor <= sensor + 2'd1;
            mstep  <= '0;
            sflag  <= 1'b0;
            state  <= BS_MAC;
          end
        end
        BS_OUT: begin
          if (!out_valid || out_ready) begin
            out_data  <= {flags, angles[3], angles[2], angles[1], angles[0]};
            out_valid <= 1'b1;
            state     <= BS_IDLE;
          end
        end
        default: state <= BS_IDLE;
      endcase
    end
  end

  // The restoring divider keeps its remainder below the divisor.
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == BS_DIV) |-> (rem < dabs_r))
    else $error("divider remainder reached the divisor");

  // Vectoring starts from a nonnegative x and only grows it.
  a_vec_x: assert property (@(posedge clk) disable iff (rst)
    (state == BS_VEC) |-> !vx[AW-1])
    else $error("vectoring x went negative");

  // A result appears only from the output stage of the sequencer.
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == BS_OUT))
    else $error("result shown without a finished item");

  // A request taken from the queue starts the sequencer at the first sensor and multiply step.
  a_take: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == BS_MAC && sensor == 2'd0 && mstep == 4'd0))
    else $error("sequencer did not start on a new request");

endmodule

FILE: src/sweep_beacon_angle_model_unit.sv
// Top level of the sweep angle unit: configuration registers, front end, queue, back end.
`timescale 1ns / 1ps
//
// The unit takes a car pose and returns the sweep angles that one base station
// sees at four sensors on the car, together with a per-sensor saturation flag.
// Requests enter on the s_axis channel (tvalid/tready/tdata) and results leave on
// the m_axis channel; each moves when tvalid and tready are both high.
// The front end handles one request at a time (accept, 30 CORDIC steps for the
// heading and tilt sine/cosine, hand-off) and then takes the next one while the
// back end is still busy; a two-entry queue sits between them.
// The back end serves one sensor at a time through a multiply-accumulate unit,
// one vectoring CORDIC, a restoring divider and a square root unit. Sensors
// whose flag is set skip at least one of the vectoring passes and finish sooner.
// Results sit in an output register, so a stalled receiver holds the back end
// only once the next result is ready; the front end and queue keep filling.
// Reset (rst, synchronous) empties the pipeline and restores the station pose,
// identity rotation, zero tilt and zero sensor offsets. Configuration is written
// through cfg_we/cfg_addr/cfg_wdata, and the user must do so only while idle (unenforced).
module sweep_beacon_angle_model_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // car_x [23:0], car_y [47:24], car_heading [66:48], zero fill [71:67]
  input  logic [sba_pkg::IN_W-1:0]     s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // angle_0 [18:0], angle_1 [37:19], angle_2 [56:38], angle_3 [75:57], range_flags [79:76]
  output logic [sba_pkg::OUT_W-1:0]    m_axis_tdata,
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_addr,
  input  logic [63:0]                  cfg_wdata
);

  logic [62:0] station_position;
  logic [62:0] rotation_row_0, rotation_row_1, rotation_row_2;
  logic [17:0] plane_tilt;
  logic [63:0] sensor_x_offsets, sensor_y_offsets;

  always_ff @(posedge clk) begin
    if (rst) begin
      station_position <= '0;
      rotation_row_0   <= 63'd524288;
      rotation_row_1   <= 63'd1099511627776;
      rotation_row_2   <= 63'd2305843009213693952;
      plane_tilt       <= '0;
      sensor_x_offsets <= '0;
      sensor_y_offsets <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        sba_pkg::REG_STATION: station_position <= cfg_wdata[62:0];
        sba_pkg::REG_ROT0:    rotation_row_0   <= cfg_wdata[62:0];
        sba_pkg::REG_ROT1:    rotation_row_1   <= cfg_wdata[62:0];
        sba_pkg::REG_ROT2:    rotation_row_2   <= cfg_wdata[62:0];
        sba_pkg::REG_TILT:    plane_tilt       <= cfg_wdata[17:0];
        sba_pkg::REG_OFFS_X:  sensor_x_offsets <= cfg_wdata;
        sba_pkg::REG_OFFS_Y:  sensor_y_offsets <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic               fq_valid, fq_ready, qb_valid, qb_ready;
  sba_pkg::sba_item_t fq_item, qb_item;

  sba_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .car_x       ($signed(s_axis_tdata[23:0])),
    .car_y       ($signed(s_axis_tdata[47:24])),
    .car_heading ($signed(s_axis_tdata[66:48])),
    .plane_tilt  ($signed(plane_tilt)),
    .out_valid   (fq_valid),
    .out_ready   (fq_ready),
    .out_item    (fq_item)
  );

  sba_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_item  (fq_item),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_item  (qb_item)
  );

  sba_back u_back (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (qb_valid),
    .in_ready         (qb_ready),
    .in_item          (qb_item),
    .station_position (station_position),
    .rotation_row_0   (rotation_row_0),
    .rotation_row_1   (rotation_row_1),
    .rotation_row_2   (rotation_row_2),
    .sensor_x_offsets (sensor_x_offsets),
    .sensor_y_offsets (sensor_y_offsets),
    .out_valid        (m_axis_tvalid),
    .out_ready        (m_axis_tready),
    .out_data         (m_axis_tdata)
  );

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the sweep angle unit: scoreboard, stimulus and checks.
`timescale 1ns / 1ps

// Holds a copy of the configuration, predicts the four sweep angles and flags
// for each accepted pose request, and compares results in order.
class angle_scoreboard;
  localparam longint ANGLE_PI   = 64'sd3373259426;
  localparam longint ANGLE_HALF = 64'sd1686629713;
  localparam longint ANGLE_2PI  = 64'sd6746518852;
  localparam longint TRIG_GAIN  = 64'sd652032874;
  localparam int     STEPS      = 30;
  localparam int     FRAC       = 16;

  longint unsigned   cfg_regs[7];
  longint            arctan_tab[STEPS];
  logic [79:0]       pending_angles[$];
  int                errors;

  function new();
    int i, k, e;
    longint acc;
    longint unsigned t;
    errors = 0;
    cfg_regs[0] = 0;
    cfg_regs[1] = 64'd524288;
    cfg_regs[2] = 64'd1099511627776;
    cfg_regs[3] = 64'd2305843009213693952;
    cfg_regs[4] = 0;
    cfg_regs[5] = 0;
    cfg_regs[6] = 0;
    arctan_tab[0] = 64'sd843314857;
    for (i = 1; i < STEPS; i++) begin
      acc = 0;
      for (k = 0; k < 64; k++) begin
        e = 62 - i * (2 * k + 1);
        if (e < 0) break;
        t = (64'd1 << e) / longint'(2 * k + 1);
        if (k & 1) acc -= longint'(t);
        else acc += longint'(t);
      end
      arctan_tab[i] = (acc + (64'sd1 << 31)) >>> 32;
    end
  endfunction

  function void set_reg(logic [2:0] idx, logic [63:0] value);
    if (idx == sba_pkg::REG_TILT) cfg_regs[idx] = value & 64'h3ffff;
    else if (idx == sba_pkg::REG_OFFS_X || idx == sba_pkg::REG_OFFS_Y) cfg_regs[idx] = value;
    else if (idx <= sba_pkg::REG_ROT2) cfg_regs[idx] = value & 64'h7fffffffffffffff;
  endfunction

  function longint sign_field(longint unsigned v, int w);
    longint r;
    r = longint'(v & ((64'd1 << w) - 1));
    if ((v >> (w - 1)) & 1) r -= (64'sd1 << w);
    return r;
  endfunction

  function longint round_shift(longint v, int s);
    return (v + (64'sd1 << (s - 1))) >>> s;
  endfunction

  function longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else res >>= 1;
      bitv >>= 2;
    end
    return res;
  endfunction

  // Rotation-mode CORDIC with the angle folded into plus or minus a quarter turn.
  function void rotate_trig(longint a, output longint c, output longint s);
    longint r, x, y, z, dx, dy;
    bit neg;
    r = a % ANGLE_2PI;
    x = TRIG_GAIN;
    y = 0;
    neg = 0;
    if (r > ANGLE_PI) r -= ANGLE_2PI;
    if (r < -ANGLE_PI) r += ANGLE_2PI;
    if (r > ANGLE_HALF) begin
      r -= ANGLE_PI;
      neg = 1;
    end else if (r < -ANGLE_HALF) begin
      r += ANGLE_PI;
      neg = 1;
    end
    z = r;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_tab[i];
      end else begin
        x += dx; y -= dy; z += arctan_tab[i];
      end
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endfunction

  function longint vector_angle(longint x, longint y, output longint mag);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += arctan_tab[i];
      end else begin
        x -= dx; y += dy; z -= arctan_tab[i];
      end
    end
    mag = x;
    return z;
  endfunction

  function longint arcsine_term(longint num, longint den, inout bit flag);
    bit neg;
    longint unsigned n, d, rem, q, c;
    longint ang, unused_mag;
    q = 0;
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    neg = num < 0;
    n = neg ? longint'(0) - num : num;
    d = den;
    if (d == 0) begin
      flag = 1;
      if (n == 0) return 0;
      return neg ? -ANGLE_HALF : ANGLE_HALF;
    end
    if (n >= d) begin
      if (n > d) flag = 1;
      return neg ? -ANGLE_HALF : ANGLE_HALF;
    end
    rem = n;
    for (int i = 0; i < 30; i++) begin
      rem <<= 1;
      q <<= 1;
      if (rem >= d) begin
        rem -= d;
        q |= 1;
      end
    end
    c = int_sqrt((64'd1 << 60) - q * q);
    ang = vector_angle(longint'(c), longint'(q), unused_mag);
    return neg ? -ang : ang;
  endfunction

  function logic [79:0] sweep_angles(logic [71:0] pose);
    longint cx, cy, hc, hs, tc, ts, ox, oy, a1, r, mag, ang;
    longint st[3], rm[3][3], d[3], b[3];
    logic [79:0] res;
    bit flag;
    res = '0;
    cx = sign_field(pose[23:0], 24);
    cy = sign_field(pose[47:24], 24);
    rotate_trig(sign_field(pose[66:48], 19) * (64'sd1 << (30 - FRAC)), hc, hs);
    rotate_trig(sign_field(cfg_regs[sba_pkg::REG_TILT], 18) * (64'sd1 << (30 - FRAC)), tc, ts);
    for (int j = 0; j < 3; j++) begin
      st[j] = sign_field(cfg_regs[sba_pkg::REG_STATION] >> (21 * j), 21) * 16;
      for (int k = 0; k < 3; k++)
        rm[j][k] = sign_field(cfg_regs[sba_pkg::REG_ROT0 + j] >> (21 * k), 21);
    end
    for (int i = 0; i < 4; i++) begin
      flag = 0;
      ox = sign_field(cfg_regs[sba_pkg::REG_OFFS_X] >> (16 * i), 16);
      oy = sign_field(cfg_regs[sba_pkg::REG_OFFS_Y] >> (16 * i), 16);
      d[0] = cx + round_shift(hc * ox - hs * oy, 26) - st[0];
      d[1] = cy + round_shift(hs * ox + hc * oy, 26) - st[1];
      d[2] = -st[2];
      for (int k = 0; k < 3; k++)
        b[k] = round_shift(rm[0][k] * d[0] + rm[1][k] * d[1] + rm[2][k] * d[2], 19);
      if (b[0] == 0) begin
        // Sensor straight above or below the station axis: atan term by sign only.
        flag = 1;
        a1 = b[1] > 0 ? ANGLE_HALF : (b[1] < 0 ? -ANGLE_HALF : 0);
        r = b[1] < 0 ? -b[1] : b[1];
      end else begin
        if (b[0] < 0) a1 = vector_angle(-b[0], -b[1], mag);
        else a1 = vector_angle(b[0], b[1], mag);
        r = round_shift(mag * TRIG_GAIN, 30);
      end
      ang = a1 + arcsine_term(b[2] * ts, r * tc, flag);
      ang = round_shift(ang, 30 - FRAC);
      if (ang > 262143) ang = 262143;
      if (ang < -262144) ang = -262144;
      res[19*i +: 19] = ang[18:0];
      res[76 + i] = flag;
    end
    return res;
  endfunction

  function void note_pose(logic [71:0] pose);
    pending_angles.push_back(sweep_angles(pose));
  endfunction

  function void check_angles(logic [79:0] got);
    logic [79:0] want;
    if (pending_angles.size() == 0) begin
      $display("%0t: result with no request pending: %h", $time, got);
      errors++;
      return;
    end
    want = pending_angles.pop_front();
    for (int i = 0; i < 4; i++)
      if (want[19*i +: 19] !== got[19*i +: 19]) begin
        $display("%0t: angle_%0d expected %h actual %h", $time, i,
                 want[19*i +: 19], got[19*i +: 19]);
        errors++;
      end
    if (want[79:76] !== got[79:76]) begin
      $display("%0t: range_flags expected %h actual %h", $time, want[79:76], got[79:76]);
      errors++;
    end
  endfunction
endclass

module tb;
  localparam int CYCLE_LIMIT = 8000000;
  localparam int LONG_HOLD   = 3000;
  localparam int MAX_GAP     = 18;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [79:0] m_axis_tdata;
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [63:0] cfg_wdata;

  angle_scoreboard angle_sb;
  bit  send_busy_free;   // when set, the sender never idles
  bit  recv_busy_free;   // when set, the receiver never stalls
  bit  hold_req;
  int  hold_left;
  int  recv_gap;
  int  cycles;

  sweep_beacon_angle_model_unit dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // The whole run is bounded by a cycle count; running past it is a failure.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Receiver: checks every accepted result and stalls at random. A long hold
  // requested by the main sequence is counted down here so that the sender
  // keeps offering requests and the unit backs up into its input.
  initial begin
    m_axis_tready = 0;
    hold_left = 0;
    recv_gap = 0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (m_axis_tvalid && m_axis_tready) begin
          angle_sb.check_angles(m_axis_tdata);
          recv_gap = recv_busy_free ? 0 : $urandom_range(0, MAX_GAP);
        end else if (recv_gap > 0) recv_gap--;
        if (hold_req) begin
          hold_req = 0;
          hold_left = LONG_HOLD;
        end else if (hold_left > 0) hold_left--;
        m_axis_tready <= (hold_left == 0) && (recv_gap == 0);
      end
    end
  end

  // One write per call; the enable is dropped again before the task returns, so
  // consecutive writes never assign it twice in one step.
  task automatic write_reg(logic [2:0] idx, logic [63:0] value);
    cfg_we    <= 1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 0;
    angle_sb.set_reg(idx, value);
    @(posedge clk);
  endtask

  // Offers one pose request and returns once it has been accepted. The valid
  // is lowered only when a gap follows, so it never toggles within one step.
  task automatic send_pose(logic signed [23:0] px, logic signed [23:0] py,
                           logic signed [18:0] heading);
    int gap;
    logic [71:0] pose;
    pose = {5'd0, heading, py, px};
    gap = send_busy_free ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= pose;
    do @(posedge clk); while (!s_axis_tready);
    angle_sb.note_pose(pose);
  endtask

  // Stops offering and waits until every predicted result has come back.
  task automatic drain();
    s_axis_tvalid <= 0;
    @(posedge clk);
    while (angle_sb.pending_angles.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_random_poses(int count);
    for (int n = 0; n < count; n++)
      send_pose(24'($urandom), 24'($urandom), 19'($urandom_range(0, 411774) - 205887));
  endtask

  task automatic randomize_config();
    write_reg(sba_pkg::REG_STATION, {$urandom, $urandom});
    write_reg(sba_pkg::REG_ROT0, {$urandom, $urandom});
    write_reg(sba_pkg::REG_ROT1, {$urandom, $urandom});
    write_reg(sba_pkg::REG_ROT2, {$urandom, $urandom});
    write_reg(sba_pkg::REG_TILT, 64'($signed($urandom_range(0, 205888)) - 102944));
    write_reg(sba_pkg::REG_OFFS_X, {$urandom, $urandom});
    write_reg(sba_pkg::REG_OFFS_Y, {$urandom, $urandom});
  endtask

  initial begin
    angle_sb = new();
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    cfg_we = 0;
    cfg_addr = '0;
    cfg_wdata = '0;
    send_busy_free = 0;
    recv_busy_free = 0;
    hold_req = 0;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Reset configuration: station at the origin, identity rotation, no offsets.
    // A car at the origin has zero range, a car on the y axis has zero bx.
    send_pose(0, 0, 0);
    send_pose(0, 24'sd327680, 0);
    send_pose(0, -24'sd327680, 19'sd102944);
    send_pose(24'sd65536, 0, 0);
    send_pose(-24'sd65536, 24'sd1, -19'sd102944);
    send_pose(24'sd8388607, 24'sd8388607, 19'sd205887);
    send_pose(-24'sd8388608, -24'sd8388608, -19'sd205887);
    send_pose(-24'sd8388608, 24'sd8388607, 19'sd0);
    drain();

    // Station raised high with a steep tilt: the asin argument overshoots one.
    write_reg(sba_pkg::REG_STATION, {21'sd8192, 21'sd0, 21'sd0});
    write_reg(sba_pkg::REG_TILT, 64'sd102944);
    write_reg(sba_pkg::REG_OFFS_X, 64'h8000_7fff_0100_ff00);
    write_reg(sba_pkg::REG_OFFS_Y, 64'h7fff_8000_ff00_0100);
    send_pose(24'sd65536, 24'sd0, 0);
    send_pose(24'sd655360, 24'sd65536, 19'sd51472);
    send_pose(0, 0, 19'sd205887);
    send_pose(-24'sd8388608, 24'sd8388607, -19'sd205887);
    drain();
    write_reg(sba_pkg::REG_TILT, -64'sd102944);
    send_pose(24'sd131072, -24'sd131072, 0);
    send_pose(24'sd8388607, 0, 19'sd1);
    drain();

    // Extreme registers: station fields all ones, rotation all zeros, so every
    // sensor lands on the degenerate path.
    write_reg(sba_pkg::REG_STATION, 64'h7fff_ffff_ffff_ffff);
    write_reg(sba_pkg::REG_ROT0, 64'd0);
    write_reg(sba_pkg::REG_ROT1, 64'd0);
    write_reg(sba_pkg::REG_ROT2, 64'd0);
    write_reg(sba_pkg::REG_OFFS_X, 64'hffff_ffff_ffff_ffff);
    write_reg(sba_pkg::REG_OFFS_Y, 64'd0);
    send_pose(24'sd12345, -24'sd54321, 19'sd1000);
    send_pose(0, 0, 0);
    drain();

    // Full-scale rotation entries and the widest station values.
    write_reg(sba_pkg::REG_ROT0, 64'h7fff_ffff_ffff_ffff);
    write_reg(sba_pkg::REG_ROT1, {1'b0, 21'h100000, 21'h0fffff, 21'h100000});
    write_reg(sba_pkg::REG_ROT2, {1'b0, 21'h0fffff, 21'h100000, 21'h0fffff});
    write_reg(sba_pkg::REG_STATION, {1'b0, 21'h100000, 21'h0fffff, 21'h100000});
    send_random_poses(4);
    drain();

    // Back to an identity frame with a mild tilt for ordinary geometry.
    write_reg(sba_pkg::REG_STATION, {21'sd4096, 21'sd2048, -21'sd4096});
    write_reg(sba_pkg::REG_ROT0, 64'd524288);
    write_reg(sba_pkg::REG_ROT1, 64'd1099511627776);
    write_reg(sba_pkg::REG_ROT2, 64'd2305843009213693952);
    write_reg(sba_pkg::REG_TILT, 64'sd20000);
    write_reg(sba_pkg::REG_OFFS_X, {16'sd800, -16'sd800, 16'sd800, -16'sd800});
    write_reg(sba_pkg::REG_OFFS_Y, {16'sd600, 16'sd600, -16'sd600, -16'sd600});
    send_random_poses(280);
    drain();

    // Long receiver hold while requests keep coming: the unit fills and stalls.
    hold_req = 1;
    send_random_poses(280);
    drain();

    // A stretch with neither side idling.
    send_busy_free = 1;
    recv_busy_free = 1;
    send_random_poses(280);
    drain();
    send_busy_free = 0;
    recv_busy_free = 0;

    for (int phase = 0; phase < 4; phase++) begin
      randomize_config();
      send_random_poses(260);
      drain();
    end

    repeat (700) @(posedge clk);
    if (angle_sb.errors == 0 && angle_sb.pending_angles.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      if (angle_sb.pending_angles.size() != 0)
        $display("%0t: %0d expected results never arrived", $time,
                 angle_sb.pending_angles.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

FILE: sim.f
src/sba_pkg.sv
src/sba_front.sv
src/sba_queue.sv
src/sba_back.sv
src/sweep_beacon_angle_model_unit.sv
sim/tb.sv
